// ===== design/ppot_pkg.sv =====
`default_nettype none

package ppot_pkg;

  // Width of the owner field and the number of codes it can carry.
  localparam int OWNER_W      = 4;
  localparam int OWNER_VALUES = 1 << OWNER_W;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ACQUIRE = 3'd2,
    OP_RELEASE = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // Status codes of a result transaction.
  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_NOT_HELD    = 3'd2,
    ST_WRONG_OWNER = 3'd3,
    ST_ENTRY       = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  // Input transaction as it arrives on the port.
  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         slot_index;
    logic [OWNER_W-1:0] owner_id;
    logic [2:0]         request_priority;
    logic [3:0]         listener_id;
  } item_t;

  // Result transaction as it leaves on the port.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] result_slot;
    logic       displaced;
    logic [3:0] displaced_listener;
    logic       last;
  } result_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic [5:0]         slot;
    logic [OWNER_W-1:0] owner;
    logic [2:0]         prio;
    logic [3:0]         listener;
  } cmd_t;

  // One word of the slot table.
  typedef struct packed {
    logic               managed;
    logic               held;
    logic [OWNER_W-1:0] owner;
    logic [2:0]         prio;
    logic [3:0]         listener;
  } entry_t;

  // Sequencer states of the back end.
  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/ppot_ram.sv =====
`default_nettype none

module ppot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ppot_front.sv =====
`default_nettype none

module ppot_front #(
  parameter int NUM_SLOTS       = 64,
  parameter int NUM_OWNERS      = 16,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppot_pkg::item_t command,
  output logic            full,
  input  logic            clearing,
  output logic            cmd_valid,
  output ppot_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);
  import ppot_pkg::*;

  localparam logic [2:0] PRIO_MAX =
    (PRIORITY_LEVELS - 1 > 7) ? 3'd7 : 3'(PRIORITY_LEVELS - 1);

  logic [OWNER_W-1:0] owner_tab [OWNER_VALUES];
  cmd_t               cls;
  logic               known;
  logic               enq;
  logic               deq;
  cmd_t               q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  // Owner codes folded into the owner range, worked out at elaboration.
  for (genvar i = 0; i < OWNER_VALUES; i++) begin : g_owner
    assign owner_tab[i] = OWNER_W'(i % NUM_OWNERS);
  end

  // Classify the incoming transaction: decode, range check, normalize.
  always_comb begin
    known  = 1'b1;
    cls.op = OP_ADD;
    case (command.operation)
      OP_ADD:     cls.op = OP_ADD;
      OP_REMOVE:  cls.op = OP_REMOVE;
      OP_ACQUIRE: cls.op = OP_ACQUIRE;
      OP_RELEASE: cls.op = OP_RELEASE;
      OP_QUERY:   cls.op = OP_QUERY;
      default:    known  = 1'b0;
    endcase
    cls.in_range = int'(command.slot_index) < NUM_SLOTS;
    cls.slot     = command.slot_index;
    cls.owner    = owner_tab[command.owner_id];
    cls.prio     = (command.request_priority > PRIO_MAX) ? PRIO_MAX
                                                         : command.request_priority;
    cls.listener = command.listener_id;
  end

  // Unknown operations are taken and dropped here.
  assign full      = clearing || (count == 2'd2);
  assign enq       = push && !full && known;
  assign deq       = cmd_valid && cmd_pop;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // Two-entry command queue toward the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        q[wr_ptr] <= cls;
        wr_ptr    <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, enq} - {1'b0, deq});
    end
  end

endmodule

`default_nettype wire

// ===== design/ppot_back.sv =====
`default_nettype none

module ppot_back #(
  parameter int NUM_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  ppot_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              clearing,
  input  logic              pop,
  output logic              empty,
  output ppot_pkg::result_t result
);
  import ppot_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] END_COUNT = CNT_W'(NUM_SLOTS);

  back_state_t          state;
  back_state_t          state_next;
  cmd_t                 cur;
  logic [CNT_W-1:0]     scan_pointer;
  logic [SLOT_W-1:0]    eval_slot;
  logic                 pend_valid;
  logic [SLOT_W-1:0]    pend_slot;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t               rd_entry;
  entry_t               wr_entry;
  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic [SLOT_W-1:0]    raddr;
  logic                 qualify;
  logic                 scan_stall;
  logic                 scan_more;
  logic                 start;
  result_t              out_res;
  logic                 out_push;
  logic                 out_full;
  logic                 out_pop;
  result_t              oq [2];
  logic                 o_wr;
  logic                 o_rd;
  logic [1:0]           o_count;

  ppot_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_entry = entry_t'(rdata);

  // A scanned slot is listed if managed and free or held at lower priority.
  assign qualify    = rd_entry.managed && !(rd_entry.held && rd_entry.prio >= cur.prio);
  assign scan_stall = qualify && pend_valid && out_full;
  assign scan_more  = (scan_pointer != END_COUNT);
  assign start      = cmd_valid && !out_full;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (scan_pointer == LAST_SLOT) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (start) state_next = (cmd.op == OP_QUERY) ? BK_SCAN : BK_EXEC;
      end
      BK_EXEC: begin
        state_next = BK_IDLE;
      end
      BK_SCAN: begin
        if (!scan_stall && !scan_more) state_next = BK_FINISH;
      end
      BK_FINISH: begin
        if (!out_full) state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: table access and result generation.
  always_comb begin
    clearing = 1'b0;
    cmd_pop  = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = SLOT_W'(cur.slot);
    wr_entry = rd_entry;
    out_push = 1'b0;
    out_res  = '{status: ST_DONE, result_slot: cur.slot, displaced: 1'b0,
                 displaced_listener: 4'd0, last: 1'b1};
    case (state)
      BK_CLEAR: begin
        clearing = 1'b1;
        we       = 1'b1;
        waddr    = scan_pointer[SLOT_W-1:0];
        wr_entry = '0;
      end
      BK_IDLE: begin
        cmd_pop = start;
        if (cmd.op != OP_QUERY && cmd.in_range) raddr = SLOT_W'(cmd.slot);
      end
      BK_EXEC: begin
        out_push = 1'b1;
        case (cur.op)
          OP_ADD, OP_REMOVE: begin
            we               = cur.in_range;
            wr_entry.managed = (cur.op == OP_ADD);
          end
          OP_ACQUIRE: begin
            wr_entry.held     = 1'b1;
            wr_entry.owner    = cur.owner;
            wr_entry.prio     = cur.prio;
            wr_entry.listener = cur.listener;
            if (!cur.in_range) begin
              out_res.status = ST_REFUSED;
            end else if (!rd_entry.held) begin
              we = 1'b1;
            end else if (rd_entry.prio < cur.prio) begin
              we                         = 1'b1;
              out_res.displaced          = 1'b1;
              out_res.displaced_listener = rd_entry.listener;
            end else begin
              out_res.status = ST_REFUSED;
            end
          end
          OP_RELEASE: begin
            wr_entry.held = 1'b0;
            if (!cur.in_range || !rd_entry.held) begin
              out_res.status = ST_NOT_HELD;
            end else if (rd_entry.owner != cur.owner) begin
              out_res.status = ST_WRONG_OWNER;
            end else begin
              we = 1'b1;
            end
          end
          default: begin
            out_push = 1'b0;
          end
        endcase
      end
      BK_SCAN: begin
        // On a stall the current slot is read again so its data stays.
        if (scan_stall) begin
          raddr = eval_slot;
        end else if (scan_more) begin
          raddr = scan_pointer[SLOT_W-1:0];
        end
        out_push            = qualify && pend_valid && !out_full;
        out_res.status      = ST_ENTRY;
        out_res.result_slot = 6'(pend_slot);
        out_res.last        = 1'b0;
      end
      BK_FINISH: begin
        out_push = !out_full;
        if (pend_valid) begin
          out_res.status      = ST_ENTRY;
          out_res.result_slot = 6'(pend_slot);
        end else begin
          out_res.status      = ST_EMPTY;
          out_res.result_slot = 6'd0;
        end
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  // Sequencer registers, walk pointer and the held-back list entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      scan_pointer <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        BK_CLEAR: begin
          scan_pointer <= (scan_pointer == LAST_SLOT) ? '0 : scan_pointer + 1'b1;
        end
        BK_IDLE: begin
          if (start && cmd.op == OP_QUERY) begin
            scan_pointer <= CNT_W'(1);
            eval_slot    <= '0;
            pend_valid   <= 1'b0;
          end
        end
        BK_SCAN: begin
          if (!scan_stall) begin
            if (qualify) begin
              pend_valid <= 1'b1;
              pend_slot  <= eval_slot;
            end
            if (scan_more) begin
              eval_slot    <= scan_pointer[SLOT_W-1:0];
              scan_pointer <= scan_pointer + 1'b1;
            end
          end
        end
        BK_FINISH: begin
          scan_pointer <= '0;
        end
        default: begin
          scan_pointer <= scan_pointer;
        end
      endcase
    end
  end

  // Command latch for the transaction in flight.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // Two-entry result queue toward the output port.
  assign out_full = (o_count == 2'd2);
  assign empty    = (o_count == 2'd0);
  assign out_pop  = pop && !empty;
  assign result   = oq[o_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
      o_count <= 2'd0;
    end else begin
      if (out_push) begin
        oq[o_wr] <= out_res;
        o_wr     <= !o_wr;
      end
      if (out_pop) begin
        o_rd <= !o_rd;
      end
      o_count <= 2'(o_count + {1'b0, out_push} - {1'b0, out_pop});
    end
  end

endmodule

`default_nettype wire

// ===== design/priority_preemptive_ownership_table_unit.sv =====
`default_nettype none

// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------
// command   | push / full        | ppot_pkg::item_t
// result    | pop / empty        | ppot_pkg::result_t
//
// Add, remove, acquire and release each make one table read and at most one
// write back through the slot table.
// During a query the walk reads one slot per cycle and holds while the result
// queue is full.
// After reset the table is cleared slot by slot with full held high.
// Unknown operation codes are accepted and produce no result.

module priority_preemptive_ownership_table_unit #(
  parameter int NUM_SLOTS       = 64,
  parameter int NUM_OWNERS      = 16,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ppot_pkg::item_t   command,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output ppot_pkg::result_t result
);
  import ppot_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic clearing;

  // Front end: accept, classify and queue commands.
  ppot_front #(
    .NUM_SLOTS       (NUM_SLOTS),
    .NUM_OWNERS      (NUM_OWNERS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .command   (command),
    .full      (full),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: table access and result queue.
  ppot_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== design/ppot_checker.sv =====
`default_nettype none

module ppot_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input ppot_pkg::result_t result
);
  import ppot_pkg::*;

  // Coming out of reset there are no results and the table is being cleared.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results visible right after reset");

  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("commands taken while the table is cleared");

  // List results never carry displacement information.
  a_list_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == ST_ENTRY || result.status == ST_EMPTY))
      |-> (!result.displaced && result.displaced_listener == 4'd0))
    else $error("list result carries a displaced listener");

  // An empty-list result stands alone and names slot zero.
  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_EMPTY) |-> (result.last && result.result_slot == 6'd0))
    else $error("malformed empty-list result");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before being taken");

endmodule

bind priority_preemptive_ownership_table_unit ppot_checker u_checker (.*);

`default_nettype wire

// ===== test/priority_preemptive_ownership_table_unit_tb.sv =====
`timescale 1ns / 1ps

module priority_preemptive_ownership_table_unit_tb;
  import ppot_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 200;
  localparam int RANDOM_CMDS = 83;

  logic    clk;
  logic    rst     = 1'b1;
  logic    push    = 1'b0;
  item_t   command = '0;
  logic    full;
  logic    pop     = 1'b0;
  logic    empty;
  result_t result;

  priority_preemptive_ownership_table_unit uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .command(command),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // Tracks the slot table and holds the results each accepted command owes.
  class slot_table_tracker;
    bit         is_managed[SLOTS];
    bit         is_held[SLOTS];
    logic [3:0] rec_owner[SLOTS];
    logic [2:0] rec_prio[SLOTS];
    logic [3:0] rec_listener[SLOTS];
    result_t    due_results[$];
    int         mismatches;
    int         compared;
    int         commands;
    int         queries;

    function new();
      mismatches = 0;
      compared   = 0;
      commands   = 0;
      queries    = 0;
    endfunction

    // Applies one accepted command to the table and queues what it must return.
    // Owner and priority fields already fit the configured ranges, so the
    // modulo and saturation rules leave them unchanged.
    function void record_command(item_t cmd);
      result_t r;
      int      listed;
      int      s;
      commands++;
      r = '0;
      r.result_slot = cmd.slot_index;
      r.last = 1'b1;
      case (cmd.operation)
        OP_ADD, OP_REMOVE: begin
          is_managed[cmd.slot_index] = (cmd.operation == OP_ADD);
          r.status = ST_DONE;
          due_results.push_back(r);
        end
        OP_ACQUIRE: begin
          if (!is_held[cmd.slot_index]) begin
            is_held[cmd.slot_index] = 1'b1;
            r.status = ST_DONE;
          end else if (rec_prio[cmd.slot_index] < cmd.request_priority) begin
            r.status             = ST_DONE;
            r.displaced          = 1'b1;
            r.displaced_listener = rec_listener[cmd.slot_index];
          end else begin
            r.status = ST_REFUSED;
          end
          if (r.status == ST_DONE) begin
            rec_owner[cmd.slot_index]    = cmd.owner_id;
            rec_prio[cmd.slot_index]     = cmd.request_priority;
            rec_listener[cmd.slot_index] = cmd.listener_id;
          end
          due_results.push_back(r);
        end
        OP_RELEASE: begin
          if (!is_held[cmd.slot_index]) begin
            r.status = ST_NOT_HELD;
          end else if (rec_owner[cmd.slot_index] != cmd.owner_id) begin
            r.status = ST_WRONG_OWNER;
          end else begin
            is_held[cmd.slot_index] = 1'b0;
            r.status = ST_DONE;
          end
          due_results.push_back(r);
        end
        OP_QUERY: begin
          queries++;
          listed = 0;
          // Walk managed slots in ascending order; the last entry gets the mark.
          for (s = 0; s < SLOTS; s++) begin
            if (is_managed[s] && !(is_held[s] && rec_prio[s] >= cmd.request_priority)) begin
              r = '0;
              r.status      = ST_ENTRY;
              r.result_slot = s[5:0];
              due_results.push_back(r);
              listed++;
            end
          end
          if (listed == 0) begin
            r = '0;
            r.status = ST_EMPTY;
            r.last   = 1'b1;
            due_results.push_back(r);
          end else begin
            due_results[$].last = 1'b1;
          end
        end
        default: begin
          // Unknown codes leave the table alone and return nothing.
        end
      endcase
    endfunction

    // Compares one result transaction with the oldest outstanding one.
    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d last %0d",
               got.status, got.result_slot, got.last);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compared++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.result_slot !== want.result_slot) begin
        $error("result_slot: expected %0d, actual %0d", want.result_slot, got.result_slot);
        mismatches++;
      end
      if (got.displaced !== want.displaced) begin
        $error("displaced: expected %0d, actual %0d", want.displaced, got.displaced);
        mismatches++;
      end
      if (got.displaced_listener !== want.displaced_listener) begin
        $error("displaced_listener: expected %0d, actual %0d",
               want.displaced_listener, got.displaced_listener);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  slot_table_tracker tracker = new();
  int burst_left = 0;
  int cycle_count = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("priority_preemptive_ownership_table_unit: mismatch");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick the next pop.
  // The stall mode is drawn at random from four patterns and redrawn periodically.
  initial begin : result_sink
    int rx_cycle;
    int rx_mode;
    rx_cycle = 0;
    rx_mode  = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) tracker.compare_result(result);
      if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (rx_cycle % 5 == 0);
        default: pop <= (rx_cycle % 48 >= 20);
      endcase
      rx_cycle++;
    end
  end

  function automatic item_t make_cmd(logic [2:0] op, logic [5:0] slot, logic [3:0] owner,
                                     logic [2:0] prio, logic [3:0] listener);
    item_t c;
    c.operation        = op;
    c.slot_index       = slot;
    c.owner_id         = owner;
    c.request_priority = prio;
    c.listener_id      = listener;
    return c;
  endfunction

  // Offers one command and returns once the block has taken the transaction.
  // Commands go out in bursts of random length with random gaps in between.
  task automatic send_cmd(item_t cmd);
    if (burst_left == 0) begin
      if (push) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    command <= cmd;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.record_command(cmd);
    burst_left--;
  endtask

  // Random command, mostly well formed: slots from a small pool so that
  // acquires collide, and releases usually by the current holder.
  function automatic item_t random_cmd();
    item_t c;
    int    pick;
    c = make_cmd(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 3) != 0) c.slot_index = 6'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 15) c.operation = OP_ADD;
    else if (pick < 25) c.operation = OP_REMOVE;
    else if (pick < 55) c.operation = OP_ACQUIRE;
    else if (pick < 80) c.operation = OP_RELEASE;
    else if (pick < 95) c.operation = OP_QUERY;
    else c.operation = 3'($urandom_range(5, 7));
    if (c.operation == OP_RELEASE && tracker.is_held[c.slot_index] &&
        $urandom_range(0, 9) < 7) begin
      c.owner_id = tracker.rec_owner[c.slot_index];
    end
    return c;
  endfunction

  // Main sequence: reset, directed commands, random commands, drain.
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Nothing managed yet, so the list comes back empty.
    send_cmd(make_cmd(OP_QUERY, 6'd0, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_ADD, 6'd0, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_ADD, 6'd63, 4'd15, 3'd7, 4'd15));
    send_cmd(make_cmd(OP_ADD, 6'd5, 4'd0, 3'd0, 4'd0));
    // Grant on a free slot, refusal at equal priority, then displacement.
    send_cmd(make_cmd(OP_ACQUIRE, 6'd0, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 6'd0, 4'd1, 3'd0, 4'd3));
    send_cmd(make_cmd(OP_ACQUIRE, 6'd0, 4'd15, 3'd7, 4'd15));
    send_cmd(make_cmd(OP_ACQUIRE, 6'd0, 4'd2, 3'd7, 4'd1));
    send_cmd(make_cmd(OP_ACQUIRE, 6'd63, 4'd9, 3'd3, 4'd10));
    send_cmd(make_cmd(OP_QUERY, 6'd0, 4'd0, 3'd3, 4'd0));
    send_cmd(make_cmd(OP_QUERY, 6'd63, 4'd15, 3'd7, 4'd15));
    // Release by another owner, by the holder, and of a free slot.
    send_cmd(make_cmd(OP_RELEASE, 6'd0, 4'd3, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 6'd0, 4'd15, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 6'd0, 4'd15, 3'd0, 4'd0));
    // Acquire ignores the managed mark; remove keeps the holder record.
    send_cmd(make_cmd(OP_ACQUIRE, 6'd40, 4'd4, 3'd5, 4'd6));
    send_cmd(make_cmd(OP_REMOVE, 6'd63, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_QUERY, 6'd0, 4'd0, 3'd7, 4'd0));
    // Unknown operation codes give no result.
    send_cmd(make_cmd(3'd5, 6'd0, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(3'd6, 6'd21, 4'd5, 3'd2, 4'd9));
    send_cmd(make_cmd(3'd7, 6'd63, 4'd15, 3'd7, 4'd15));
    send_cmd(make_cmd(OP_ADD, 6'd63, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_QUERY, 6'd0, 4'd0, 3'd4, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 6'd63, 4'd9, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_REMOVE, 6'd63, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_REMOVE, 6'd0, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_REMOVE, 6'd5, 4'd0, 3'd0, 4'd0));
    send_cmd(make_cmd(OP_QUERY, 6'd0, 4'd0, 3'd7, 4'd0));

    repeat (RANDOM_CMDS) send_cmd(random_cmd());
    push <= 1'b0;

    // Drain outstanding results, then allow for a trailing ignored command.
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tracker.due_results.size() != 0) begin
      $error("%0d results never arrived", tracker.due_results.size());
      tracker.mismatches++;
    end
    $display("Sent %0d commands (%0d queries) with bursty input and a stalling result side.",
             tracker.commands, tracker.queries);
    $display("Compared %0d result transactions, %0d field mismatches.",
             tracker.compared, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("priority_preemptive_ownership_table_unit: match");
    end else begin
      $display("priority_preemptive_ownership_table_unit: mismatch");
    end
    $finish;
  end

endmodule
